/* rtl/sac_pkg.sv */
// Shared types and constants of the set-associative LRU cache tag model.
// No dependencies; every other file in rtl/ imports this package.
package sac_pkg;

    localparam int MAX_SETS_DEF = 256;
    localparam int MAX_WAYS_DEF = 8;
    localparam int TAG_W        = 30;
    localparam int SET_IDX_W    = 12;   // covers the largest set count allowed
    localparam int CFG_DATA_W   = 11;
    localparam int CFG_IDX_W    = 2;

    localparam logic [3:0]  OFFSET_BITS_RST = 4'd4;
    localparam logic [3:0]  INDEX_BITS_RST  = 4'd6;
    localparam logic [3:0]  WAYS_RST        = 4'd1;
    localparam logic [10:0] BLOCK_WORDS_RST = 11'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET_BITS = 2'd0,
        CFG_INDEX_BITS  = 2'd1,
        CFG_WAYS_IN_USE = 2'd2,
        CFG_BLOCK_WORDS = 2'd3
    } t_cfg_idx;

    localparam logic       OP_ACCESS = 1'b0;
    localparam logic       OP_FLUSH  = 1'b1;
    localparam logic [1:0] KIND_INST  = 2'd0;
    localparam logic [1:0] KIND_STORE = 2'd2;

    typedef struct packed {
        logic [3:0]  offset_bits;
        logic [3:0]  index_bits;
        logic [3:0]  ways_in_use;
        logic [10:0] block_words;
    } t_cfg;

    typedef struct packed {
        logic        opcode;
        logic [31:0] address;
        logic [1:0]  access_kind;
    } t_in_item;

    typedef struct packed {
        logic        hit;
        logic        replaced;
        logic        wrote_back;
        logic [31:0] inst_accesses;
        logic [31:0] inst_misses;
        logic [31:0] inst_replacements;
        logic [31:0] data_accesses;
        logic [31:0] data_misses;
        logic [31:0] data_replacements;
        logic [31:0] fetch_words;
        logic [31:0] copyback_words;
    } t_out_item;

    // Classified item as it waits between front and back.
    typedef struct packed {
        logic                 is_flush;
        logic                 is_inst;
        logic                 is_store;
        logic [SET_IDX_W-1:0] idx;
        logic [TAG_W-1:0]     tag;
    } t_job;

endpackage

/* rtl/sac_front.sv */
// Front end: decodes an accepted item into set index, tag and kind flags.
// Depends on sac_pkg.
module sac_front #(
    parameter int MAX_SETS = sac_pkg::MAX_SETS_DEF
) (
    input  sac_pkg::t_in_item i_item,
    input  sac_pkg::t_cfg     i_cfg,
    output sac_pkg::t_job     o_job
);
    import sac_pkg::*;

    localparam int MIB = $clog2(MAX_SETS + 1) - 1;

    logic [3:0]  ob;
    logic [3:0]  ib;
    logic [31:0] blk;
    logic [31:0] idx_mask;
    logic [31:0] tag_full;

    always_comb begin
        ob       = (i_cfg.offset_bits < 4'd2) ? 4'd2 : i_cfg.offset_bits;
        ib       = (32'(i_cfg.index_bits) > 32'(MIB)) ? 4'(MIB) : i_cfg.index_bits;
        blk      = i_item.address >> ob;
        idx_mask = (32'd1 << ib) - 32'd1;
        tag_full = blk >> ib;   // offset plus index stays below 32
        o_job.is_flush = (i_item.opcode == OP_FLUSH);
        o_job.is_inst  = (i_item.access_kind == KIND_INST);
        o_job.is_store = (i_item.access_kind == KIND_STORE);
        o_job.idx      = SET_IDX_W'(blk & idx_mask);
        o_job.tag      = tag_full[TAG_W-1:0];
    end

endmodule

/* rtl/sac_fifo.sv */
// Two-entry queue of classified jobs between front and back.
// Depends on sac_pkg.
module sac_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sac_pkg::t_job i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_vld,
    output sac_pkg::t_job o_data
);
    import sac_pkg::*;

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full = (r_cnt == 2'd2);
    assign o_vld  = (r_cnt != 2'd0);
    assign o_data = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

endmodule

/* rtl/sac_back.sv */
// Back end: set memories, LRU update, flush walk, counters, result register.
// Depends on sac_pkg.
module sac_back #(
    parameter int MAX_SETS = sac_pkg::MAX_SETS_DEF,
    parameter int MAX_WAYS = sac_pkg::MAX_WAYS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sac_pkg::t_cfg      i_cfg,
    input  logic               i_q_vld,
    input  sac_pkg::t_job      i_q_job,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output sac_pkg::t_out_item o_item
);
    import sac_pkg::*;

    localparam int IW   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAYW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int FW   = $clog2(MAX_WAYS + 1);
    localparam logic [WAYW-1:0] AGE_MAX = WAYW'(MAX_WAYS - 1);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ACC   = 3'b010,
        ST_FLUSH = 3'b100
    } t_state;

    typedef logic [MAX_WAYS-1:0][TAG_W-1:0] t_tag_row;
    typedef logic [MAX_WAYS-1:0][WAYW-1:0]  t_age_row;

    t_tag_row             r_mem_tag   [MAX_SETS];
    t_age_row             r_mem_age   [MAX_SETS];
    logic [MAX_WAYS-1:0]  r_mem_dirty [MAX_SETS];
    logic [FW-1:0]        r_mem_fill  [MAX_SETS];
    logic [MAX_SETS-1:0]  r_row_vld;

    t_state        r_state, n_state;
    t_job          r_job;
    logic [IW-1:0] r_wr_addr;
    t_tag_row      r_rd_tag;
    t_age_row      r_rd_age;
    logic [MAX_WAYS-1:0] r_rd_dirty;
    logic [FW-1:0] r_rd_fill;
    logic          r_rd_vld;
    logic          r_fl_wb;
    logic          r_out_vld;
    t_out_item     r_out;
    t_out_item     n_out;

    logic [31:0] r_ia, r_im, r_ir, r_da, r_dm, r_dr, r_fw, r_cb;
    logic [31:0] n_ia, n_im, n_ir, n_da, n_dm, n_dr, n_fw, n_cb;

    logic [IW-1:0]       ra;
    logic                rd_en;
    logic                we_row;
    logic                we_dirty;
    logic                out_load;
    logic [FW-1:0]       fill, wy, nw;
    logic [MAX_WAYS-1:0] dirty;
    logic                hit, fill_path, repl, wb;
    logic [WAYW-1:0]     hit_way, victim, sel, a_sel;
    t_tag_row            n_tag;
    t_age_row            n_age;
    logic [MAX_WAYS-1:0] n_dirty;
    logic [FW-1:0]       n_fill;
    logic [MAX_WAYS-1:0] fl_dmask;
    logic [FW-1:0]       fl_cnt;
    logic [31:0]         fl_add;
    logic                fl_last;

    assign o_valid = r_out_vld;
    assign o_item  = r_out;

    // Set lookup and LRU update on the registered row.
    always_comb begin
        fill  = r_rd_vld ? r_rd_fill : '0;
        dirty = r_rd_vld ? r_rd_dirty : '0;
        if (i_cfg.ways_in_use == 4'd0) begin
            wy = FW'(1);
        end else if (32'(i_cfg.ways_in_use) > 32'(MAX_WAYS)) begin
            wy = FW'(MAX_WAYS);
        end else begin
            wy = FW'(i_cfg.ways_in_use);
        end
        nw = (fill < wy) ? fill : wy;

        hit     = 1'b0;
        hit_way = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (FW'(w) < nw && r_rd_tag[w] == r_job.tag) begin
                hit     = 1'b1;
                hit_way = WAYW'(w);
            end
        end

        victim = '0;
        for (int v = 1; v < MAX_WAYS; v++) begin
            if (FW'(v) < nw && r_rd_age[v] > r_rd_age[victim]) victim = WAYW'(v);
        end

        fill_path = !hit && (fill < wy);
        repl      = !hit && !fill_path;
        wb        = repl && dirty[victim];
        sel       = hit ? hit_way : (fill_path ? WAYW'(fill) : victim);
        a_sel     = r_rd_age[sel];

        n_age = r_rd_age;
        for (int v = 0; v < MAX_WAYS; v++) begin
            if (FW'(v) < nw && (fill_path || r_rd_age[v] < a_sel) &&
                r_rd_age[v] < AGE_MAX) begin
                n_age[v] = r_rd_age[v] + WAYW'(1);
            end
        end
        n_age[sel] = '0;

        n_tag = r_rd_tag;
        if (!hit) n_tag[sel] = r_job.tag;

        n_dirty = dirty;
        if (!hit || r_job.is_store) n_dirty[sel] = r_job.is_store;

        n_fill = fill_path ? fill + FW'(1) : fill;

        // Flush: count dirty ways below the fill.
        for (int w = 0; w < MAX_WAYS; w++) begin
            fl_dmask[w] = dirty[w] && (FW'(w) < fill);
        end
        fl_cnt  = FW'($countones(fl_dmask));
        fl_add  = 32'(fl_cnt) * 32'(i_cfg.block_words);
        fl_last = (r_wr_addr == IW'(MAX_SETS - 1));
    end

    // Sequencer.
    always_comb begin
        n_state  = r_state;
        o_pop    = 1'b0;
        rd_en    = 1'b0;
        ra       = r_wr_addr + IW'(1);
        we_row   = 1'b0;
        we_dirty = 1'b0;
        out_load = 1'b0;
        n_ia = r_ia; n_im = r_im; n_ir = r_ir;
        n_da = r_da; n_dm = r_dm; n_dr = r_dr;
        n_fw = r_fw; n_cb = r_cb;
        n_out = r_out;
        case (r_state)
            ST_IDLE: begin
                ra = i_q_job.is_flush ? '0 : i_q_job.idx[IW-1:0];
                if (i_q_vld && (!r_out_vld || !i_stall)) begin
                    o_pop   = 1'b1;
                    rd_en   = 1'b1;
                    n_state = i_q_job.is_flush ? ST_FLUSH : ST_ACC;
                end
            end
            ST_ACC: begin
                we_row   = 1'b1;
                we_dirty = 1'b1;
                out_load = 1'b1;
                if (r_job.is_inst) begin
                    n_ia = r_ia + 32'd1;
                    if (!hit) n_im = r_im + 32'd1;
                    if (repl) n_ir = r_ir + 32'd1;
                end else begin
                    n_da = r_da + 32'd1;
                    if (!hit) n_dm = r_dm + 32'd1;
                    if (repl) n_dr = r_dr + 32'd1;
                end
                if (!hit) n_fw = r_fw + 32'(i_cfg.block_words);
                if (wb)   n_cb = r_cb + 32'(i_cfg.block_words);
                n_out.hit        = hit;
                n_out.replaced   = repl;
                n_out.wrote_back = wb;
                n_state = ST_IDLE;
            end
            ST_FLUSH: begin
                rd_en    = !fl_last;
                we_dirty = r_rd_vld;
                n_cb     = r_cb + fl_add;
                if (fl_last) begin
                    out_load = 1'b1;
                    n_out.hit        = 1'b0;
                    n_out.replaced   = 1'b0;
                    n_out.wrote_back = r_fl_wb || (fl_cnt != '0);
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        n_out.inst_accesses     = n_ia;
        n_out.inst_misses       = n_im;
        n_out.inst_replacements = n_ir;
        n_out.data_accesses     = n_da;
        n_out.data_misses       = n_dm;
        n_out.data_replacements = n_dr;
        n_out.fetch_words       = n_fw;
        n_out.copyback_words    = n_cb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_row_vld <= '0;
            r_out_vld <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_fl_wb   <= 1'b0;
            r_ia <= '0; r_im <= '0; r_ir <= '0;
            r_da <= '0; r_dm <= '0; r_dr <= '0;
            r_fw <= '0; r_cb <= '0;
        end else begin
            r_state <= n_state;
            r_ia <= n_ia; r_im <= n_im; r_ir <= n_ir;
            r_da <= n_da; r_dm <= n_dm; r_dr <= n_dr;
            r_fw <= n_fw; r_cb <= n_cb;
            if (rd_en) r_rd_vld <= r_row_vld[ra];
            if (we_row) r_row_vld[r_wr_addr] <= 1'b1;
            if (o_pop) r_fl_wb <= 1'b0;
            else if (r_state == ST_FLUSH && fl_cnt != '0) r_fl_wb <= 1'b1;
            if (out_load) r_out_vld <= 1'b1;
            else if (!i_stall) r_out_vld <= 1'b0;
        end
    end

    // Payload and memories.
    always_ff @(posedge i_clk) begin
        if (o_pop) r_job <= i_q_job;
        if (rd_en) r_wr_addr <= ra;
        if (out_load) r_out <= n_out;
        if (we_row) begin
            r_mem_tag[r_wr_addr]  <= n_tag;
            r_mem_age[r_wr_addr]  <= n_age;
            r_mem_fill[r_wr_addr] <= n_fill;
        end
        if (we_dirty) begin
            r_mem_dirty[r_wr_addr] <= (r_state == ST_FLUSH) ? '0 : n_dirty;
        end
        if (rd_en) begin
            r_rd_tag   <= r_mem_tag[ra];
            r_rd_age   <= r_mem_age[ra];
            r_rd_dirty <= r_mem_dirty[ra];
            r_rd_fill  <= r_mem_fill[ra];
        end
    end

endmodule

/* rtl/set_assoc_lru_cache_tag_model.sv */
// Top level of the set-associative LRU write-back cache tag model.
// Depends on sac_pkg, sac_front, sac_fifo and sac_back.
//
// Usage:
//   Input channel (i_valid / o_stall / i_item) takes access or flush items;
//   an item is taken at an edge with i_valid high and o_stall low.
//   Output channel (o_valid / i_stall / o_item) returns one result per item
//   with the hit, replaced and wrote_back flags and all running counters.
//   Config port (i_cfg_we / i_cfg_idx / i_cfg_data) writes one register per
//   edge; write only while the block is idle.
//   In the back end an access reads its set row, then does lookup, LRU
//   update and row write; it reaches o_item through the job queue, the row
//   read register and the result register. The back end starts the next
//   item only after the row read-modify-write of the last one is done.
//   A flush walks every set, one row per cycle.
//   A 2-entry job queue decouples the front; o_stall rises only when it is
//   full. When the receiver stalls, the result register holds and the back
//   end waits before starting the next item.
//   Reset clears configuration to its defaults, the counters and a per-set
//   valid bit, so every set reads as empty with no dirty lines at once;
//   there is no clearing pass. Tags and ages are kept in memory without
//   reset and are read only for ways below a set's fill.
module set_assoc_lru_cache_tag_model #(
    parameter int MAX_SETS = sac_pkg::MAX_SETS_DEF,
    parameter int MAX_WAYS = sac_pkg::MAX_WAYS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  sac_pkg::t_in_item                  i_item,
    output logic                               o_valid,
    input  logic                               i_stall,
    output sac_pkg::t_out_item                 o_item,
    input  logic                               i_cfg_we,
    input  logic [sac_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [sac_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import sac_pkg::*;

    t_cfg r_cfg;
    t_job front_job;
    t_job q_job;
    logic q_full;
    logic q_vld;
    logic q_pop;
    logic push;

    // Hold configuration; each register keeps only its own width.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.offset_bits <= OFFSET_BITS_RST;
            r_cfg.index_bits  <= INDEX_BITS_RST;
            r_cfg.ways_in_use <= WAYS_RST;
            r_cfg.block_words <= BLOCK_WORDS_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_OFFSET_BITS: r_cfg.offset_bits <= i_cfg_data[3:0];
                CFG_INDEX_BITS:  r_cfg.index_bits  <= i_cfg_data[3:0];
                CFG_WAYS_IN_USE: r_cfg.ways_in_use <= i_cfg_data[3:0];
                CFG_BLOCK_WORDS: r_cfg.block_words <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Classify the item on the way into the queue.
    sac_front #(.MAX_SETS(MAX_SETS)) u_front (
        .i_item (i_item),
        .i_cfg  (r_cfg),
        .o_job  (front_job)
    );

    assign o_stall = q_full;
    assign push    = i_valid && !q_full;

    sac_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_vld   (q_vld),
        .o_data  (q_job)
    );

    sac_back #(.MAX_SETS(MAX_SETS), .MAX_WAYS(MAX_WAYS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_q_vld (q_vld),
        .i_q_job (q_job),
        .o_pop   (q_pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    // Drop a job only when the queue holds one.
    a_pop_needs_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_vld)
        else $error("back end popped an empty queue");

    // No two jobs are popped back to back; each job holds the back end until it is done.
    a_pop_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> !q_pop)
        else $error("back end popped on consecutive cycles");

    // A new job starts only when the result register can take its result.
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> (!o_valid || !i_stall))
        else $error("job started while a stalled result still waits");

endmodule

/* tb/tb_set_assoc_lru_cache_tag_model.sv */
// Self-checking testbench for set_assoc_lru_cache_tag_model: a cache-model predictor,
// random idling on both channels and register sweeps.
// Depends on sac_pkg and the RTL of the block.
module tb_set_assoc_lru_cache_tag_model;
    import sac_pkg::*;

    localparam int NSETS     = 256;
    localparam int NWAYS     = 8;
    localparam int IDX_MAX   = 8;      // log2 of NSETS
    localparam int AGE_MAX   = NWAYS - 1;
    localparam int STALL_CAP = 3000;   // idle cycles before the watchdog fires

    logic       i_clk;
    logic       i_rst_n;
    logic       in_valid;
    logic       in_stall;
    t_in_item   in_item;
    logic       out_valid;
    logic       out_stall;
    t_out_item  out_item;
    logic       cfg_we;
    t_cfg_idx   cfg_idx;
    logic [10:0] cfg_data;

    set_assoc_lru_cache_tag_model dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (in_valid),
        .o_stall    (in_stall),
        .i_item     (in_item),
        .o_valid    (out_valid),
        .i_stall    (out_stall),
        .o_item     (out_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Shadow copy of the cache state and the register file.
    logic [29:0] shadow_tag   [NSETS*NWAYS];
    logic        shadow_dirty [NSETS*NWAYS];
    logic [2:0]  shadow_age   [NSETS*NWAYS];
    int          shadow_fill  [NSETS];
    logic [3:0]  reg_offset, reg_index, reg_ways;
    logic [10:0] reg_words;
    logic [31:0] n_iacc, n_imiss, n_irepl, n_dacc, n_dmiss, n_drepl, n_fetch, n_copyback;

    t_in_item  pending_items[$];
    t_out_item expected_results[$];
    int        queued_count;
    int        checked_count;
    int        errors;
    int        idle_cycles;
    int        idle_pct;       // chance of starting an idle burst, percent
    int        send_gap;
    int        recv_gap;
    logic      sent_last;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic void age_up(int pos);
        if (shadow_age[pos] < AGE_MAX) shadow_age[pos] = shadow_age[pos] + 3'd1;
    endfunction

    // Make way w most recent; every way younger than it grows one older.
    function automatic void promote_way(int base, int n, int w);
        logic [2:0] a;
        a = shadow_age[base+w];
        for (int v = 0; v < n; v++) begin
            if (shadow_age[base+v] < a) age_up(base+v);
        end
        shadow_age[base+w] = 3'd0;
    endfunction

    function automatic t_out_item cache_lookup(t_in_item it);
        t_out_item r;
        int ob, ib, nw, fill, n, w, victim, base;
        logic [31:0] idx, tg;
        logic is_inst, is_store;
        r = '0;
        if (it.opcode == OP_FLUSH) begin
            // Walk every filled way, even past a shrunk associativity.
            for (int s = 0; s < NSETS; s++) begin
                for (int v = 0; v < shadow_fill[s]; v++) begin
                    if (shadow_dirty[s*NWAYS+v]) begin
                        n_copyback = n_copyback + reg_words;
                        shadow_dirty[s*NWAYS+v] = 1'b0;
                        r.wrote_back = 1'b1;
                    end
                end
            end
        end else begin
            is_inst  = (it.access_kind == KIND_INST);
            is_store = (it.access_kind == KIND_STORE);
            ob = (reg_offset < 2) ? 2 : int'(reg_offset);
            ib = (reg_index > IDX_MAX) ? IDX_MAX : int'(reg_index);
            nw = (reg_ways == 0) ? 1 : ((reg_ways > NWAYS) ? NWAYS : int'(reg_ways));
            idx  = (it.address >> ob) & ((32'd1 << ib) - 32'd1);
            tg   = (ob + ib >= 32) ? 32'd0 : (it.address >> (ob + ib));
            base = int'(idx) * NWAYS;
            fill = shadow_fill[idx];
            n    = (fill < nw) ? fill : nw;
            if (is_inst) n_iacc = n_iacc + 1;
            else         n_dacc = n_dacc + 1;
            w = n;
            for (int v = n - 1; v >= 0; v--) begin
                if (shadow_tag[base+v] == tg[29:0]) w = v;
            end
            if (w < n) begin
                r.hit = 1'b1;
                promote_way(base, n, w);
                if (is_store) shadow_dirty[base+w] = 1'b1;
            end else begin
                if (is_inst) n_imiss = n_imiss + 1;
                else         n_dmiss = n_dmiss + 1;
                n_fetch = n_fetch + reg_words;
                if (fill < nw) begin
                    // Fill the next empty way.
                    for (int v = 0; v < n; v++) age_up(base+v);
                    shadow_tag[base+fill]   = tg[29:0];
                    shadow_dirty[base+fill] = is_store;
                    shadow_age[base+fill]   = 3'd0;
                    shadow_fill[idx]        = fill + 1;
                end else begin
                    // Evict the oldest way, lowest index on a tie.
                    victim = 0;
                    for (int v = 1; v < n; v++) begin
                        if (shadow_age[base+v] > shadow_age[base+victim]) victim = v;
                    end
                    if (shadow_dirty[base+victim]) begin
                        n_copyback   = n_copyback + reg_words;
                        r.wrote_back = 1'b1;
                    end
                    shadow_tag[base+victim]   = tg[29:0];
                    shadow_dirty[base+victim] = is_store;
                    promote_way(base, n, victim);
                    if (is_inst) n_irepl = n_irepl + 1;
                    else         n_drepl = n_drepl + 1;
                    r.replaced = 1'b1;
                end
            end
        end
        r.inst_accesses     = n_iacc;
        r.inst_misses       = n_imiss;
        r.inst_replacements = n_irepl;
        r.data_accesses     = n_dacc;
        r.data_misses       = n_dmiss;
        r.data_replacements = n_drepl;
        r.fetch_words       = n_fetch;
        r.copyback_words    = n_copyback;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t mismatch %s: expected %0h actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    // Sender: hold a stalled item, otherwise idle in bursts or advance.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (in_valid && !sent_last) begin
            in_valid <= 1'b1;
        end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            in_valid <= 1'b0;
        end else if (pending_items.size() > 0 && $urandom_range(99) < idle_pct) begin
            send_gap <= $urandom_range(18);
            in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
            in_item  <= pending_items.pop_front();
            in_valid <= 1'b1;
        end else begin
            in_valid <= 1'b0;
        end
    end

    // Receiver: stall in bursts of random length.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap  <= recv_gap - 1;
            out_stall <= 1'b1;
        end else if ($urandom_range(99) < idle_pct) begin
            recv_gap  <= $urandom_range(18);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Monitor: predict on every accepted item, check every accepted result.
    always @(posedge i_clk) begin
        t_out_item exp_r;
        sent_last <= in_valid && !in_stall;
        if (i_rst_n) begin
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t unexpected result %0h", $time, out_item);
                    errors++;
                end else begin
                    exp_r = expected_results.pop_front();
                    check_field("hit", exp_r.hit, out_item.hit);
                    check_field("replaced", exp_r.replaced, out_item.replaced);
                    check_field("wrote_back", exp_r.wrote_back, out_item.wrote_back);
                    check_field("inst_accesses", exp_r.inst_accesses, out_item.inst_accesses);
                    check_field("inst_misses", exp_r.inst_misses, out_item.inst_misses);
                    check_field("inst_replacements", exp_r.inst_replacements,
                                out_item.inst_replacements);
                    check_field("data_accesses", exp_r.data_accesses, out_item.data_accesses);
                    check_field("data_misses", exp_r.data_misses, out_item.data_misses);
                    check_field("data_replacements", exp_r.data_replacements,
                                out_item.data_replacements);
                    check_field("fetch_words", exp_r.fetch_words, out_item.fetch_words);
                    check_field("copyback_words", exp_r.copyback_words,
                                out_item.copyback_words);
                end
                checked_count++;
            end
            if (in_valid && !in_stall) expected_results.push_back(cache_lookup(in_item));
            if ((out_valid && !out_stall) || (in_valid && !in_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_CAP) begin
                $display("FAIL set_assoc_lru_cache_tag_model");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic add_item(logic op, logic [31:0] addr, logic [1:0] kind);
        t_in_item it;
        it.opcode      = op;
        it.address     = addr;
        it.access_kind = kind;
        pending_items.push_back(it);
        queued_count++;
    endtask

    // Hold until every queued item has returned its result, then settle.
    task automatic drain();
        while (checked_count != queued_count) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx r, logic [10:0] v);
        @(negedge i_clk);
        cfg_we   = 1'b1;
        cfg_idx  = r;
        cfg_data = v;
        case (r)
            CFG_OFFSET_BITS: reg_offset = v[3:0];
            CFG_INDEX_BITS:  reg_index  = v[3:0];
            CFG_WAYS_IN_USE: reg_ways   = v[3:0];
            default:         reg_words  = v;
        endcase
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_cache(logic [3:0] ob, logic [3:0] ib, logic [3:0] nw, logic [10:0] bw);
        write_reg(CFG_OFFSET_BITS, {7'd0, ob});
        write_reg(CFG_INDEX_BITS, {7'd0, ib});
        write_reg(CFG_WAYS_IN_USE, {7'd0, nw});
        write_reg(CFG_BLOCK_WORDS, bw);
    endtask

    // Random items aimed at a few tags of a few sets so hits and evictions
    // are common; a share of fully random addresses and rare flushes.
    task automatic random_items(int count, bit mid_pause);
        int ob, ib, nw, shift;
        logic [31:0] addr;
        ob = (reg_offset < 2) ? 2 : int'(reg_offset);
        ib = (reg_index > IDX_MAX) ? IDX_MAX : int'(reg_index);
        nw = (reg_ways == 0) ? 1 : ((reg_ways > NWAYS) ? NWAYS : int'(reg_ways));
        shift = ob + ib;
        for (int k = 0; k < count; k++) begin
            addr = $urandom();
            if ($urandom_range(99) < 75) begin
                addr = (addr & ((32'd1 << ob) - 32'd1))
                     | ((32'($urandom_range(3)) & ((32'd1 << ib) - 32'd1)) << ob)
                     | (32'($urandom_range(nw + 2)) << shift);
            end
            if ($urandom_range(99) < 4) add_item(OP_FLUSH, addr, 2'($urandom_range(3)));
            else                        add_item(OP_ACCESS, addr, 2'($urandom_range(3)));
            if (mid_pause && k == count / 2) drain();
        end
        drain();
    endtask

    initial begin
        cfg_we = 1'b0;
        cfg_idx = CFG_OFFSET_BITS;
        cfg_data = '0;
        in_item = '0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        send_gap = 0;
        recv_gap = 0;
        sent_last = 1'b0;
        idle_cycles = 0;
        idle_pct = 10;
        errors = 0;
        queued_count = 0;
        checked_count = 0;
        reg_offset = OFFSET_BITS_RST;
        reg_index  = INDEX_BITS_RST;
        reg_ways   = WAYS_RST;
        reg_words  = BLOCK_WORDS_RST;
        {n_iacc, n_imiss, n_irepl, n_dacc, n_dmiss, n_drepl, n_fetch, n_copyback} = '0;
        for (int i = 0; i < NSETS*NWAYS; i++) begin
            shadow_tag[i] = '0;
            shadow_dirty[i] = 1'b0;
            shadow_age[i] = '0;
        end
        for (int s = 0; s < NSETS; s++) shadow_fill[s] = 0;
        i_rst_n = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: reset settings, one way per set, 64 sets of 16 bytes.
        add_item(OP_FLUSH, 32'h0, KIND_INST);          // flush of an empty cache
        add_item(OP_ACCESS, 32'h0, KIND_INST);         // cold miss
        add_item(OP_ACCESS, 32'h4, 2'd1);              // hit in the same block
        add_item(OP_ACCESS, 32'h8, KIND_STORE);        // store hit, mark dirty
        add_item(OP_ACCESS, 32'h400, KIND_INST);       // evict the dirty line
        add_item(OP_ACCESS, 32'hFFFFFFFF, 2'd3);       // unknown kind acts as a load
        add_item(OP_ACCESS, 32'hFFFFFFF0, KIND_STORE);
        add_item(OP_FLUSH, 32'hFFFFFFFF, 2'd3);        // flush finds a dirty line
        add_item(OP_FLUSH, 32'h0, KIND_STORE);         // nothing left dirty
        add_item(OP_ACCESS, 32'h0, KIND_STORE);
        add_item(OP_ACCESS, 32'h400, KIND_STORE);      // dirty evicts dirty
        add_item(OP_ACCESS, 32'h0, 2'd1);
        add_item(OP_ACCESS, 32'h8000_0000, KIND_INST);
        drain();
        random_items(60, 1'b1);

        // Extremes: tiny offset acts as 2, single set, free traffic.
        set_cache(4'd0, 4'd0, 4'd1, 11'd0);
        random_items(50, 1'b0);
        set_cache(4'd12, 4'd8, 4'd8, 11'd1024);
        idle_pct = 0;
        random_items(90, 1'b0);
        idle_pct = 15;
        // Shrink associativity under filled sets.
        set_cache(4'd12, 4'd8, 4'd3, 11'd2047);
        random_items(70, 1'b0);
        // Out of range: index saturates, ways 0 acts as 1.
        set_cache(4'd15, 4'd15, 4'd0, 11'd7);
        random_items(60, 1'b0);
        set_cache(4'd3, 4'd2, 4'd15, 11'd100);
        random_items(100, 1'b0);
        set_cache(4'd2, 4'd1, 4'd4, 11'd1);
        random_items(100, 1'b0);
        // Last part of the run without idling.
        idle_pct = 0;
        set_cache(4'd5, 4'd3, 4'd2, 11'd16);
        random_items(100, 1'b0);

        if (errors == 0 && expected_results.size() == 0) begin
            $display("PASS set_assoc_lru_cache_tag_model");
        end else begin
            $display("FAIL set_assoc_lru_cache_tag_model");
        end
        $finish;
    end

endmodule
